/* rtl/dictionary_markup_stripper_macros.svh */
// Assertion macros for the checker file of the markup stripper.
`ifndef DICTIONARY_MARKUP_STRIPPER_MACROS_SVH
`define DICTIONARY_MARKUP_STRIPPER_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define DMS_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, off while reset is low.
`define DMS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("next-cycle implication failed");

// Next-cycle implication that also holds across reset.
`define DMS_ASSERT_NEXT_RAW(label, clk, pre, post) \
    label: assert property (@(posedge clk) (pre) |=> (post)) \
        else $error("next-cycle implication across reset failed");

`endif

/* rtl/dms_pkg.sv */
// Types, byte codes and the head decision shared by the markup stripper modules.
`default_nettype none

package dms_pkg;

    localparam int LEN_W       = 17;
    localparam int QUEUE_DEPTH = 4;

    typedef logic [LEN_W-1:0] t_len;

    localparam logic [7:0] C_LF       = 8'h0A;
    localparam logic [7:0] C_SPC_MARK = 8'h06;
    localparam logic [7:0] C_RUN_18   = 8'h18;
    localparam logic [7:0] C_ESC      = 8'h1B;
    localparam logic [7:0] C_LEN_BIAS = 8'h3F;
    localparam logic [7:0] C_HIGH     = 8'h40;
    localparam logic [7:0] C_RUN_28   = 8'h28;
    localparam logic [7:0] C_PFX_50   = 8'h50;
    localparam logic [7:0] C_PFX_60   = 8'h60;
    localparam logic [7:0] C_DROP_14  = 8'h14;
    localparam logic [7:0] C_SUB_02   = 8'h02;
    localparam logic [7:0] C_RUN_1A   = 8'h1A;
    localparam logic [7:0] C_MAX_1A   = 8'd10;
    localparam logic [7:0] C_RS       = 8'h1E;
    localparam logic [7:0] C_US       = 8'h1F;
    localparam logic [7:0] C_SPACE    = 8'h20;
    localparam logic [3:0] MAX_OUT    = 4'd8;

    // "<br>", first character at index 0
    localparam logic [3:0][7:0] BR_TEXT = {8'h3E, 8'h72, 8'h62, 8'h3C};

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] bytes_left;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_definition;
    } t_out_item;

    typedef enum logic [2:0] {
        K_WAIT,
        K_NONE,
        K_BYTE,
        K_SPACE,
        K_BR
    } t_kind;

    typedef struct packed {
        t_kind kind;
        t_len  adv;
    } t_dec;

    typedef struct packed {
        logic [7:0] byte_val;
        logic [2:0] cnt;
        logic       br;
        logic       last_step;
        logic       fin;
    } t_act;

    function automatic logic [2:0] kind_cost(input t_kind k);
        logic [2:0] c;
        case (k)
            K_BR:    c = 3'd4;
            K_BYTE:  c = 3'd1;
            K_SPACE: c = 3'd1;
            default: c = 3'd0;
        endcase
        return c;
    endfunction

    function automatic t_dec decide(input logic [7:0] c, input logic [7:0] d1,
                                    input logic [7:0] d2, input logic [7:0] d3,
                                    input logic [2:0] f, input t_len r);
        t_dec res;
        t_len lc;
        t_len n1;
        t_len n2;
        t_len hi1;
        t_len hi2;
        t_len w12;
        t_len w23;
        lc  = t_len'(c) - t_len'(C_LEN_BIAS);
        n1  = t_len'(d1);
        n2  = t_len'(d2);
        hi1 = {1'b0, d1, 8'h00};
        hi2 = {1'b0, d2, 8'h00};
        w12 = {1'b0, d1, d2};
        w23 = {1'b0, d2, d3};
        res.kind = K_BYTE;
        res.adv  = t_len'(1);
        if (c == C_LF) begin
            res.kind = K_BR;
        end else if (c == C_SPC_MARK) begin
            res.kind = K_SPACE;
            if (r >= t_len'(2)) res.adv = t_len'(2);
        end else if (c >= C_HIGH && r >= t_len'(2) && f < 3'd2) begin
            res.kind = K_WAIT;
        end else if (c >= C_HIGH && r >= t_len'(2) && d1 == C_RUN_18) begin
            res.kind = K_NONE;
            if (lc <= r - t_len'(2)) res.adv = lc + t_len'(2);
        end else if (c == C_RUN_18) begin
            res.kind = K_NONE;
            if (r >= t_len'(2)) begin
                if (f < 3'd2) res.kind = K_WAIT;
                else if (n1 <= r - t_len'(2)) res.adv = n1 + t_len'(2);
            end
        end else if (c == C_RUN_28 && r >= t_len'(3)) begin
            res.kind = K_NONE;
            if (f < 3'd2) res.kind = K_WAIT;
            else if (hi1 > r - t_len'(3)) res.kind = K_NONE;
            else if (f < 3'd3) res.kind = K_WAIT;
            else if (w12 <= r - t_len'(3)) res.adv = w12 + t_len'(3);
        end else if (c == C_PFX_50 && r >= t_len'(3) && d1 == C_ESC) begin
            res.kind = K_NONE;
            if (f < 3'd3) res.kind = K_WAIT;
            else if (n2 <= r - t_len'(3)) res.adv = n2 + t_len'(3);
        end else if (c == C_PFX_60 && r >= t_len'(4) && d1 == C_ESC) begin
            res.kind = K_NONE;
            if (f < 3'd3) res.kind = K_WAIT;
            else if (hi2 > r - t_len'(4)) res.kind = K_NONE;
            else if (f < 3'd4) res.kind = K_WAIT;
            else if (w23 <= r - t_len'(4)) res.adv = w23 + t_len'(4);
        end else if (c >= C_HIGH && r >= t_len'(2) && d1 == C_ESC) begin
            res.kind = K_NONE;
            if (lc <= r - t_len'(2)) res.adv = lc + t_len'(2);
        end else if (c inside {C_RS, C_US}) begin
            res.kind = K_NONE;
        end else if (c == C_DROP_14) begin
            res.kind = K_NONE;
            if (r >= t_len'(3)) begin
                if (f < 3'd2) res.kind = K_WAIT;
                else if (d1 == C_SUB_02) res.adv = t_len'(3);
            end
        end else if (c == C_RUN_1A) begin
            res.kind = K_NONE;
            if (r >= t_len'(2)) begin
                if (f < 3'd2) res.kind = K_WAIT;
                else if (d1 <= C_MAX_1A && n1 <= r - t_len'(2)) res.adv = n1 + t_len'(2);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/dms_queue.sv */
// Action queue between the decision front and the output back of the markup stripper.
`default_nettype none

module dms_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  dms_pkg::t_act i_data,
    output logic          o_full,
    input  logic          i_rd,
    output dms_pkg::t_act o_data,
    output logic          o_empty
);
    import dms_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_act          r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          wr_en;
    logic          rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            if (rd_en) r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            if (wr_en && !rd_en) r_cnt <= r_cnt + CW'(1);
            else if (rd_en && !wr_en) r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wp] <= i_data;
    end

endmodule

`default_nettype wire

/* rtl/dms_front.sv */
// Front: lookahead window, skip counter, one head decision a cycle unless the queue is full.
`default_nettype none

module dms_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dms_pkg::t_in_item i_item,
    output logic              o_full,
    input  logic              i_qfull,
    output logic              o_qpush,
    output dms_pkg::t_act     o_act
);
    import dms_pkg::*;

    typedef enum logic {
        S_ACCEPT,
        S_DRAIN
    } t_state;

    t_state          r_state, n_state;
    logic [2:0][7:0] r_win, n_win;
    logic [1:0]      r_fill, n_fill;
    t_len            r_hr, n_hr;
    t_len            r_skip, n_skip;
    logic [3:0]      r_n, n_n;
    logic            r_last, n_last;

    logic [15:0]     bl;
    logic            last_in;
    logic [3:0][7:0] w;
    logic [3:0][7:0] sh1;
    logic [3:0][7:0] sh2;
    logic [3:0][7:0] sh3;
    logic [3:0][7:0] shk;
    logic [2:0]      f;
    t_len            r;
    logic            last;
    logic [3:0]      n;
    logic            go_acc;
    logic            go_run;
    logic            go;
    logic            skipping;
    t_dec            d0;
    t_dec            da;
    t_dec            db;
    t_dec            dc;
    t_dec            d1;
    logic [2:0]      cost0;
    logic [2:0]      e0;
    logic [2:0]      c1;
    logic [3:0]      room;
    logic            gone;
    logic [1:0]      k;
    logic            cont;
    logic            fin;

    always_comb begin
        bl      = (i_item.bytes_left == 16'd0) ? 16'd1 : i_item.bytes_left;
        last_in = (i_item.bytes_left <= 16'd1);
        w       = {8'h00, r_win};
        if (r_state == S_ACCEPT) begin
            w[r_fill] = i_item.data_byte;
            f         = {1'b0, r_fill} + 3'd1;
            r         = t_len'(bl) + t_len'(r_fill);
            last      = last_in;
            n         = 4'd0;
        end else begin
            f    = {1'b0, r_fill};
            r    = r_hr;
            last = r_last;
            n    = r_n;
        end

        skipping = (r_skip != '0);
        go_acc   = (r_state == S_ACCEPT) && i_push && !i_qfull;
        go_run   = (r_state == S_DRAIN) && !i_qfull;
        go       = go_acc || go_run;

        sh1 = {8'h00, w[3:1]};
        sh2 = {16'h0000, w[3:2]};
        sh3 = {24'h000000, w[3]};

        d0 = decide(w[0], w[1], w[2], w[3], f, r);
        da = decide(sh1[0], sh1[1], sh1[2], sh1[3], f - 3'd1, r - t_len'(1));
        db = decide(sh2[0], sh2[1], sh2[2], sh2[3], f - 3'd2, r - t_len'(2));
        dc = decide(sh3[0], sh3[1], sh3[2], sh3[3], f - 3'd3, r - t_len'(3));

        gone = (d0.adv >= t_len'(f));
        k    = d0.adv[1:0];
        case (k)
            2'd2: begin
                d1  = db;
                shk = sh2;
            end
            2'd3: begin
                d1  = dc;
                shk = sh3;
            end
            default: begin
                d1  = da;
                shk = sh1;
            end
        endcase

        cost0 = kind_cost(d0.kind);
        room  = MAX_OUT - n;
        e0    = (last && ({1'b0, cost0} > room)) ? room[2:0] : cost0;
        c1    = kind_cost(d1.kind);
        cont  = !gone && (d1.kind != K_WAIT)
                && (last || (({1'b0, n} + 5'(e0) + 5'(c1)) <= 5'(MAX_OUT)));
        fin   = last && !cont;

        o_full  = (r_state != S_ACCEPT) || i_qfull;
        o_qpush = 1'b0;
        o_act   = '{byte_val: (d0.kind == K_SPACE) ? C_SPACE : w[0],
                    cnt: e0, br: (d0.kind == K_BR), last_step: last, fin: fin};

        n_state = r_state;
        n_win   = r_win;
        n_fill  = r_fill;
        n_hr    = r_hr;
        n_skip  = r_skip;
        n_n     = r_n;
        n_last  = r_last;

        if (go_acc && skipping) begin
            o_qpush = last_in;
            o_act   = '{byte_val: 8'h00, cnt: 3'd0, br: 1'b0, last_step: 1'b1, fin: 1'b1};
            n_skip  = r_skip - t_len'(1);
            if (last_in) begin
                n_skip = '0;
                n_win  = '0;
                n_fill = '0;
                n_hr   = '0;
            end
        end else if (go) begin
            if (d0.kind == K_WAIT) begin
                // hold the window until the next byte arrives
                n_win   = w[2:0];
                n_fill  = f[1:0];
                n_hr    = r;
                n_state = S_ACCEPT;
            end else begin
                o_qpush = (e0 != 3'd0) || fin;
                if (fin) begin
                    n_win   = '0;
                    n_fill  = '0;
                    n_hr    = '0;
                    n_skip  = '0;
                    n_n     = '0;
                    n_last  = 1'b0;
                    n_state = S_ACCEPT;
                end else begin
                    if (gone) begin
                        n_skip = d0.adv - t_len'(f);
                        n_win  = '0;
                        n_fill = '0;
                        n_hr   = '0;
                    end else begin
                        n_win  = shk[2:0];
                        n_fill = f[1:0] - k;
                        n_hr   = r - t_len'(k);
                    end
                    n_n     = n + {1'b0, e0};
                    n_last  = last;
                    n_state = cont ? S_DRAIN : S_ACCEPT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCEPT;
            r_win   <= '0;
            r_fill  <= '0;
            r_hr    <= '0;
            r_skip  <= '0;
            r_n     <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_win   <= n_win;
            r_fill  <= n_fill;
            r_hr    <= n_hr;
            r_skip  <= n_skip;
            r_n     <= n_n;
            r_last  <= n_last;
        end
    end

endmodule

`default_nettype wire

/* rtl/dms_back.sv */
// Back of the markup stripper: expands queued actions into output items and marks the end.
`default_nettype none

module dms_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dms_pkg::t_act      i_act,
    input  logic               i_act_valid,
    output logic               o_act_rd,
    output logic               o_empty,
    input  logic               i_pop,
    output dms_pkg::t_out_item o_item
);
    import dms_pkg::*;

    logic [2:0] r_idx;
    logic [7:0] r_hold;
    logic       r_hold_v;
    logic       r_ov;
    t_out_item  r_out;

    logic       is_byte;
    logic [7:0] tok_byte;
    logic       ends_entry;
    logic       needs_out;
    logic       out_free;
    logic       fire;
    t_out_item  new_out;

    always_comb begin
        is_byte    = (r_idx < i_act.cnt);
        tok_byte   = i_act.br ? BR_TEXT[r_idx[1:0]] : i_act.byte_val;
        ends_entry = is_byte ? (((r_idx + 3'd1) == i_act.cnt) && !i_act.fin) : 1'b1;
        needs_out  = !is_byte || !i_act.last_step || r_hold_v;
        out_free   = !r_ov || i_pop;
        fire       = i_act_valid && (!needs_out || out_free);
        if (!is_byte) begin
            new_out = '{out_byte: r_hold_v ? r_hold : 8'h00, byte_valid: r_hold_v,
                        end_of_definition: 1'b1};
        end else if (!i_act.last_step) begin
            new_out = '{out_byte: tok_byte, byte_valid: 1'b1, end_of_definition: 1'b0};
        end else begin
            new_out = '{out_byte: r_hold, byte_valid: 1'b1, end_of_definition: 1'b0};
        end
    end

    assign o_act_rd = fire && ends_entry;
    assign o_empty  = !r_ov;
    assign o_item   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_hold_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (fire) begin
                r_idx <= ends_entry ? 3'd0 : r_idx + 3'd1;
                if (!is_byte) begin
                    r_hold_v <= 1'b0;
                end else if (i_act.last_step) begin
                    r_hold_v <= 1'b1;
                end
            end
            if (fire && needs_out) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && is_byte && i_act.last_step) r_hold <= tok_byte;
        if (fire && needs_out) r_out <= new_out;
    end

endmodule

`default_nettype wire

/* rtl/dictionary_markup_stripper.sv */
// Top level of the dictionary markup stripper: front, action queue and back.
//
// Input channel: one definition byte with its count of bytes left per item,
// taken at a clock edge with push high and full low. A count of one (or zero)
// marks the last byte of a definition.
// Output channel: cleaned bytes, "<br>" expansions and end markers, shown while
// empty is low and taken at a clock edge with pop high.
// An ordinary byte is written into the action queue when it is taken and then
// into the output register, from which it can be popped. Bytes of a
// definition's last step wait in a hold register so the final item carries
// the end flag; a definition that ends with no byte yields one bare end marker.
// Throughput: one item per cycle for plain text while pop keeps up. The front
// decides one head byte per cycle, so a step that decides several head bytes
// (a marker whose lookahead has just arrived, or held bytes released at once)
// holds full high while it makes the extra decisions. A "<br>" is four items.
// The four-entry action queue lets the front keep taking items while the
// receiver stalls; full rises once it fills.
// Reset clears the window, the skip counter, the action queue and the output
// valid flag; full is low and empty is high in the cycle after reset.
`default_nettype none

module dictionary_markup_stripper (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  dms_pkg::t_in_item  i_data,
    output logic               empty,
    input  logic               pop,
    output dms_pkg::t_out_item o_data
);
    import dms_pkg::*;

    logic q_push;
    logic q_full;
    logic q_empty;
    logic q_rd;
    t_act f_act;
    t_act q_act;

    dms_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_data),
        .o_full  (full),
        .i_qfull (q_full),
        .o_qpush (q_push),
        .o_act   (f_act)
    );

    dms_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_push),
        .i_data  (f_act),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_data  (q_act),
        .o_empty (q_empty)
    );

    dms_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_act       (q_act),
        .i_act_valid (!q_empty),
        .o_act_rd    (q_rd),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_item      (o_data)
    );

endmodule

`default_nettype wire

/* rtl/dms_checker.sv */
// Port-level checker for the markup stripper and its bind to the top level.
`default_nettype none
`include "dictionary_markup_stripper_macros.svh"

module dms_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input dms_pkg::t_in_item  i_data,
    input logic               empty,
    input logic               pop,
    input dms_pkg::t_out_item o_data
);
    import dms_pkg::*;

    `DMS_ASSERT_NEXT_RAW(a_reset_idle, i_clk, !i_rst_n, empty && !full)
    `DMS_ASSERT_NEXT_RAW(a_no_early_item, i_clk, !$past(i_rst_n) && i_rst_n && !(push && !full), empty)
    `DMS_ASSERT_IMPL(a_bare_marker_ends, i_clk, i_rst_n, !empty && !o_data.byte_valid, o_data.end_of_definition && o_data.out_byte == 8'h00)
    `DMS_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_data))

endmodule

bind dictionary_markup_stripper dms_checker u_checker (.*);

`default_nettype wire
